### sv/sil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_pkg
// Shared constants, codes and types of the sorted insert list core.
// ----------------------------------------------------------------------------
package sil_pkg;

	localparam int LIST_DEPTH  = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int ACTION_W    = 2;
	localparam int DATA_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 5;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	typedef struct packed {
		logic ins;
		logic rot;
	} cell_ctl_t;

endpackage
`default_nettype wire

### sv/sil_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_cell
// One slot of the list: compares, shifts right on insert, rotates on readout.
// ----------------------------------------------------------------------------
module sil_cell #(
	parameter int IDX = 0,
	parameter int VW  = sil_pkg::VALUE_WIDTH,
	parameter int CW  = 5
) (
	input  wire                    clk,
	input  sil_pkg::cell_ctl_t     ctl,
	input  wire  [CW-1:0]          count,
	input  wire  signed [VW-1:0]   ins_value,
	input  wire  signed [VW-1:0]   prev_value,
	input  wire                    prev_place,
	input  wire  signed [VW-1:0]   next_value,
	input  wire  signed [VW-1:0]   head_value,
	output logic signed [VW-1:0]   value,
	output logic                   place
);

	logic signed [VW-1:0] value_q;
	logic                 ge;
	logic                 tail;

	always_comb begin
		ge    = value_q >= ins_value;
		place = (CW'(IDX) < count && ge) || (CW'(IDX) == count);
		tail  = (CW'(IDX + 1) == count);
		value = value_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && place) begin
			value_q <= prev_place ? prev_value : ins_value;
		end else if (ctl.rot) begin
			value_q <= tail ? head_value : next_value;
		end
	end

endmodule
`default_nettype wire

### sv/sil_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_ctrl
// Fill count, readout sequencer and output register of the list core.
// ----------------------------------------------------------------------------
module sil_ctrl #(
	parameter int DEPTH = sil_pkg::LIST_DEPTH,
	parameter int VW    = sil_pkg::VALUE_WIDTH,
	parameter int CW    = 5
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [sil_pkg::ACTION_W-1:0]     action,
	input  wire  signed [VW-1:0]             head_value,
	output sil_pkg::cell_ctl_t               ctl,
	output logic [CW-1:0]                    count,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [sil_pkg::DATA_W-1:0]       out_value,
	output logic                             out_last,
	output logic [sil_pkg::STATUS_W-1:0]     out_status,
	output logic [sil_pkg::COUNT_W-1:0]      out_count
);

	sil_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    left_q, left_d;
	logic             out_valid_q;
	logic [sil_pkg::DATA_W-1:0]   out_value_q, val_d;
	logic                         out_last_q, last_d;
	logic [sil_pkg::STATUS_W-1:0] out_status_q;
	sil_pkg::status_t             status_d;
	logic [sil_pkg::COUNT_W-1:0]  out_count_q;
	logic                         load;
	logic                         slot_free;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		state_d   = state_q;
		count_d   = count_q;
		left_d    = left_q;
		load      = 1'b0;
		val_d     = '0;
		last_d    = 1'b1;
		status_d  = sil_pkg::ST_OK;
		ctl       = '0;
		in_ready  = 1'b0;
		case (state_q)
			sil_pkg::S_IDLE: begin
				in_ready = slot_free;
				if (in_valid && slot_free) begin
					case (sil_pkg::action_t'(action))
						sil_pkg::ACT_INSERT: begin
							load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								status_d = sil_pkg::ST_FULL;
							end else begin
								ctl.ins = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						sil_pkg::ACT_READ: begin
							if (count_q == '0) begin
								load     = 1'b1;
								status_d = sil_pkg::ST_EMPTY;
							end else begin
								state_d = sil_pkg::S_READ;
								left_d  = count_q;
							end
						end
						sil_pkg::ACT_CLEAR: begin
							load    = 1'b1;
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			sil_pkg::S_READ: begin
				if (slot_free) begin
					load    = 1'b1;
					val_d   = sil_pkg::DATA_W'(head_value);
					last_d  = (left_q == CW'(1));
					ctl.rot = 1'b1;
					left_d  = left_q - CW'(1);
					if (left_q == CW'(1)) begin
						state_d = sil_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = sil_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sil_pkg::S_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			left_q      <= left_d;
			out_valid_q <= load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q  <= val_d;
			out_last_q   <= last_d;
			out_status_q <= status_d;
			out_count_q  <= sil_pkg::COUNT_W'(count_d);
		end
	end

	assign count      = count_q;
	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

endmodule
`default_nettype wire

### sv/sorted_insert_list_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_list_core
// Bounded list of signed values kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                tuser           tlast
// s_axis   in   [31:0] value                         [1:0] action    -
// m_axis   out  [31:0] item_value, [36:32] count     [1:0] status    is_last
//
// On an insert every cell compares and shifts at once; a clear zeroes the count.
// A readout first enters the read state, then emits each stored value in turn
// as the output takes them, since the cells rotate the list past the head once.
// Reset clears the fill count, the sequencer and the output valid; the cells hold no reset.
// A stalled output holds its transfer and blocks new input transfers.
// ----------------------------------------------------------------------------
module sorted_insert_list_core #(
	parameter int LIST_DEPTH  = sil_pkg::LIST_DEPTH,
	parameter int VALUE_WIDTH = sil_pkg::VALUE_WIDTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [sil_pkg::S_TDATA_W-1:0]     s_tdata,  // value
	input  wire  [sil_pkg::ACTION_W-1:0]      s_tuser,  // action
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [sil_pkg::M_TDATA_W-1:0]     m_tdata,  // item_value, entry_count, zeros
	output logic [sil_pkg::STATUS_W-1:0]      m_tuser,  // status
	output logic                              m_tlast
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	sil_pkg::cell_ctl_t           ctl;
	logic [CW-1:0]                count;
	logic signed [VALUE_WIDTH-1:0] ins_value;
	logic signed [VALUE_WIDTH-1:0] cell_value [LIST_DEPTH];
	logic                          cell_place [LIST_DEPTH];
	logic [sil_pkg::DATA_W-1:0]    out_value;
	logic [sil_pkg::STATUS_W-1:0]  out_status;
	logic [sil_pkg::COUNT_W-1:0]   out_count;

	assign ins_value = VALUE_WIDTH'(signed'(s_tdata[sil_pkg::DATA_W-1:0]));

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		sil_cell #(
			.IDX (i),
			.VW  (VALUE_WIDTH),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count),
			.ins_value  (ins_value),
			.prev_value ((i == 0) ? ins_value : cell_value[(i == 0) ? 0 : i - 1]),
			.prev_place ((i == 0) ? 1'b0 : cell_place[(i == 0) ? 0 : i - 1]),
			.next_value (cell_value[(i == LIST_DEPTH - 1) ? 0 : i + 1]),
			.head_value (cell_value[0]),
			.value      (cell_value[i]),
			.place      (cell_place[i])
		);
	end

	sil_ctrl #(
		.DEPTH (LIST_DEPTH),
		.VW    (VALUE_WIDTH),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser),
		.head_value (cell_value[0]),
		.ctl        (ctl),
		.count      (count),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (out_value),
		.out_last   (m_tlast),
		.out_status (out_status),
		.out_count  (out_count)
	);

	assign m_tdata = {
		{(sil_pkg::M_TDATA_W - sil_pkg::DATA_W - sil_pkg::COUNT_W){1'b0}},
		out_count, out_value};
	assign m_tuser = out_status;

endmodule
`default_nettype wire
